// ===== rtl/core/msk_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msk_pkg
// Shared types and constants for the multi-source minimum spanning tree engine.
// ----------------------------------------------------------------------------
package msk_pkg;

   localparam int TYPE_W   = 2;
   localparam int NODE_W   = 11;
   localparam int WEIGHT_W = 32;
   localparam int COST_W   = 44;
   localparam int STATUS_W = 2;

   localparam int MAX_NODES_DEF = 1024;
   localparam int MAX_EDGES_DEF = 4096;

   localparam logic [TYPE_W-1:0] REQ_SOURCE = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_EDGE   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_FINISH = 2'd2;

   localparam logic [STATUS_W-1:0] ST_CONNECTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SPLIT     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
      logic [WEIGHT_W-1:0] weight;
   } edge_type;

   localparam int EDGE_W = $bits(edge_type);

endpackage
`default_nettype wire

// ===== rtl/core/msk_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msk_if
// Valid/ready channels of the spanning tree engine: request, response, CSR.
// ----------------------------------------------------------------------------
interface msk_req_if;
   logic                         valid;
   logic                         ready;
   logic [msk_pkg::TYPE_W-1:0]   req_type;
   logic [msk_pkg::NODE_W-1:0]   node_a;
   logic [msk_pkg::NODE_W-1:0]   node_b;
   logic [msk_pkg::WEIGHT_W-1:0] weight;
   modport source (output valid, req_type, node_a, node_b, weight, input ready);
   modport sink   (input valid, req_type, node_a, node_b, weight, output ready);
endinterface

interface msk_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [msk_pkg::STATUS_W-1:0] status;
   logic [msk_pkg::COST_W-1:0]   total_cost;
   modport source (output valid, status, total_cost, input ready);
   modport sink   (input valid, status, total_cost, output ready);
endinterface

interface msk_csr_if;
   logic                       valid;
   logic                       ready;
   logic [msk_pkg::NODE_W-1:0] num_nodes;
   modport source (output valid, num_nodes, input ready);
   modport sink   (input valid, num_nodes, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/msk_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msk_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module msk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/multi_source_kruskal_mst.sv =====
`default_nettype none
// Edge item: stored directly. Source item: first sets the anchor, later ones walk two trees.
// Finish: per edge a selection scan over the unsorted tail (one word a cycle)
// plus two root walks if both end nodes are in range; then one root walk per node for the connectivity check.
// Throughput: one transaction at a time, set by the single-port find loop.
// Reset and each response start a clearing pass over every parent store entry,
// during which no request is taken.
// ----------------------------------------------------------------------------
// multi_source_kruskal_mst
// Minimum spanning forest engine with merged sources, using selection order
// and union-find over a parent memory walked by one shared sequencer.
// ----------------------------------------------------------------------------
module multi_source_kruskal_mst #(
   parameter int MAX_NODES = msk_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES = msk_pkg::MAX_EDGES_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   msk_req_if.sink    req,
   msk_rsp_if.source  rsp,
   msk_csr_if.sink    csr
);

   localparam int SLOT_W = $clog2(MAX_NODES);
   localparam int NC_W   = $clog2(MAX_NODES + 1);
   localparam int EC_W   = $clog2(MAX_EDGES + 1);
   localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int NW     = msk_pkg::NODE_W;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_SEL_INIT = 4'd2;
   localparam logic [3:0] S_SEL      = 4'd3;
   localparam logic [3:0] S_SWAP     = 4'd4;
   localparam logic [3:0] S_FIND_RD  = 4'd5;
   localparam logic [3:0] S_FIND_CHK = 4'd6;
   localparam logic [3:0] S_JOIN     = 4'd7;
   localparam logic [3:0] S_CHK_INIT = 4'd8;

   localparam logic [1:0] F_A  = 2'd0;
   localparam logic [1:0] F_B  = 2'd1;
   localparam logic [1:0] F_R0 = 2'd2;
   localparam logic [1:0] F_K  = 2'd3;

   localparam logic CTX_SRC = 1'b0;
   localparam logic CTX_KRU = 1'b1;

   logic [3:0]                   state_ff, state_in;
   logic [SLOT_W-1:0]            clr_ff, clr_in;
   logic [NW-1:0]                num_nodes_ff, num_nodes_in;
   logic [EC_W-1:0]              edge_count_ff, edge_count_in;
   logic [NW-1:0]                anchor_ff, anchor_in;
   logic                         overflow_ff, overflow_in;
   logic [msk_pkg::COST_W-1:0]   cost_ff, cost_in;
   logic [EC_W-1:0]              i_ff, i_in;
   logic [EC_W-1:0]              j_ff, j_in;
   logic [EC_W-1:0]              pend_ff, pend_in;
   logic [EC_W-1:0]              best_idx_ff, best_idx_in;
   msk_pkg::edge_type            first_ff, first_in;
   msk_pkg::edge_type            best_ff, best_in;
   logic [SLOT_W-1:0]            cur_ff, cur_in;
   logic [SLOT_W-1:0]            ub_ff, ub_in;
   logic [SLOT_W-1:0]            ra_ff, ra_in;
   logic [SLOT_W-1:0]            rb_ff, rb_in;
   logic [1:0]                   stage_ff, stage_in;
   logic                         ctx_ff, ctx_in;
   logic [NC_W-1:0]              k_ff, k_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [msk_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [msk_pkg::COST_W-1:0]   total_ff, total_in;

   logic                         pr_we;
   logic [SLOT_W-1:0]            pr_waddr, pr_wdata, pr_raddr, pr_rdata;
   logic                         er_we;
   logic [EA_W-1:0]              er_waddr, er_raddr;
   msk_pkg::edge_type            er_wdata, er_rdata;
   logic [NC_W-1:0]              nn;
   logic                         req_fire;
   logic                         edge_ok;

   msk_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_NODES)) u_parent (
      .clock   (clock),
      .wr_en   (pr_we),
      .wr_addr (pr_waddr),
      .wr_data (pr_wdata),
      .rd_addr (pr_raddr),
      .rd_data (pr_rdata)
   );

   msk_ram #(.WIDTH(msk_pkg::EDGE_W), .DEPTH(MAX_EDGES)) u_edges (
      .clock   (clock),
      .wr_en   (er_we),
      .wr_addr (er_waddr),
      .wr_data (er_wdata),
      .rd_addr (er_raddr),
      .rd_data (er_rdata)
   );

   assign req.ready  = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire   = req.valid && req.ready;
   assign csr.ready  = 1'b1;
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.status = status_ff;
   assign rsp.total_cost = total_ff;

   assign nn = (32'(num_nodes_ff) > 32'(MAX_NODES)) ? NC_W'(MAX_NODES)
                                                     : NC_W'(num_nodes_ff);
   assign edge_ok = (best_ff.node_a != '0) && (32'(best_ff.node_a) <= 32'(nn)) &&
                    (best_ff.node_b != '0) && (32'(best_ff.node_b) <= 32'(nn));

   assign pr_raddr = (state_ff == S_FIND_CHK) ? pr_rdata : cur_ff;
   assign er_raddr = (state_ff == S_SEL_INIT) ? EA_W'(i_ff) : EA_W'(j_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      num_nodes_in  = num_nodes_ff;
      edge_count_in = edge_count_ff;
      anchor_in     = anchor_ff;
      overflow_in   = overflow_ff;
      cost_in       = cost_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      pend_in       = pend_ff;
      best_idx_in   = best_idx_ff;
      first_in      = first_ff;
      best_in       = best_ff;
      cur_in        = cur_ff;
      ub_in         = ub_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      stage_in      = stage_ff;
      ctx_in        = ctx_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      status_in     = status_ff;
      total_in      = total_ff;
      pr_we         = 1'b0;
      pr_waddr      = clr_ff;
      pr_wdata      = clr_ff;
      er_we         = 1'b0;
      er_waddr      = EA_W'(edge_count_ff);
      er_wdata      = '{node_a: req.node_a, node_b: req.node_b, weight: req.weight};

      if (csr.valid) begin
         num_nodes_in = csr.num_nodes;
      end

      case (state_ff)
         S_CLEAR: begin
            pr_we  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == 32'(MAX_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               case (req.req_type)
                  msk_pkg::REQ_SOURCE: begin
                     if (req.node_a != '0 && 32'(req.node_a) <= 32'(MAX_NODES)) begin
                        if (anchor_ff == '0) begin
                           anchor_in = req.node_a;
                        end else begin
                           cur_in   = SLOT_W'(anchor_ff - 1'b1);
                           ub_in    = SLOT_W'(req.node_a - 1'b1);
                           stage_in = F_A;
                           ctx_in   = CTX_SRC;
                           state_in = S_FIND_RD;
                        end
                     end
                  end
                  msk_pkg::REQ_EDGE: begin
                     if (32'(edge_count_ff) >= 32'(MAX_EDGES)) begin
                        overflow_in = 1'b1;
                     end else begin
                        er_we         = 1'b1;
                        edge_count_in = edge_count_ff + 1'b1;
                     end
                  end
                  msk_pkg::REQ_FINISH: begin
                     if (overflow_ff) begin
                        rsp_valid_in = 1'b1;
                        status_in    = msk_pkg::ST_OVERFLOW;
                        total_in     = '0;
                        state_in     = S_CLEAR;
                     end else begin
                        i_in     = '0;
                        state_in = S_SEL_INIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEL_INIT: begin
            if (i_ff == edge_count_ff) begin
               state_in = S_CHK_INIT;
            end else begin
               pend_in  = i_ff;
               j_in     = i_ff + 1'b1;
               state_in = S_SEL;
            end
         end
         S_SEL: begin
            if (pend_ff == i_ff) begin
               first_in    = er_rdata;
               best_in     = er_rdata;
               best_idx_in = i_ff;
            end else if (er_rdata.weight < best_ff.weight) begin
               best_in     = er_rdata;
               best_idx_in = pend_ff;
            end
            if (j_ff < edge_count_ff) begin
               pend_in = j_ff;
               j_in    = j_ff + 1'b1;
            end else begin
               state_in = S_SWAP;
            end
         end
         S_SWAP: begin
            er_we    = 1'b1;
            er_waddr = EA_W'(best_idx_ff);
            er_wdata = first_ff;
            if (edge_ok) begin
               cur_in   = SLOT_W'(best_ff.node_a - 1'b1);
               ub_in    = SLOT_W'(best_ff.node_b - 1'b1);
               stage_in = F_A;
               ctx_in   = CTX_KRU;
               state_in = S_FIND_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_SEL_INIT;
            end
         end
         S_FIND_RD: begin
            state_in = S_FIND_CHK;
         end
         S_FIND_CHK: begin
            if (pr_rdata == cur_ff) begin
               case (stage_ff)
                  F_A: begin
                     ra_in    = cur_ff;
                     cur_in   = ub_ff;
                     stage_in = F_B;
                     state_in = S_FIND_RD;
                  end
                  F_B: begin
                     rb_in    = cur_ff;
                     state_in = S_JOIN;
                  end
                  F_R0: begin
                     ra_in    = cur_ff;
                     k_in     = NC_W'(1);
                     cur_in   = SLOT_W'(1);
                     stage_in = F_K;
                     state_in = S_FIND_RD;
                  end
                  default: begin
                     if (cur_ff != ra_ff) begin
                        rsp_valid_in = 1'b1;
                        status_in    = msk_pkg::ST_SPLIT;
                        total_in     = '0;
                        state_in     = S_CLEAR;
                     end else if (32'(k_ff) + 1 == 32'(nn)) begin
                        rsp_valid_in = 1'b1;
                        status_in    = msk_pkg::ST_CONNECTED;
                        total_in     = cost_ff;
                        state_in     = S_CLEAR;
                     end else begin
                        k_in     = k_ff + 1'b1;
                        cur_in   = SLOT_W'(k_ff + 1'b1);
                        state_in = S_FIND_RD;
                     end
                  end
               endcase
            end else begin
               cur_in = pr_rdata;
            end
         end
         S_JOIN: begin
            if (ra_ff != rb_ff) begin
               pr_we    = 1'b1;
               pr_waddr = rb_ff;
               pr_wdata = ra_ff;
            end
            if (ctx_ff == CTX_SRC) begin
               state_in = S_IDLE;
            end else begin
               if (ra_ff != rb_ff) begin
                  cost_in = cost_ff + msk_pkg::COST_W'(best_ff.weight);
               end
               i_in     = i_ff + 1'b1;
               state_in = S_SEL_INIT;
            end
         end
         S_CHK_INIT: begin
            if (32'(nn) < 2) begin
               rsp_valid_in = 1'b1;
               status_in    = msk_pkg::ST_CONNECTED;
               total_in     = cost_ff;
               state_in     = S_CLEAR;
            end else begin
               cur_in   = '0;
               stage_in = F_R0;
               state_in = S_FIND_RD;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      if (state_in == S_CLEAR && state_ff != S_CLEAR) begin
         clr_in        = '0;
         edge_count_in = '0;
         anchor_in     = '0;
         overflow_in   = 1'b0;
         cost_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         num_nodes_ff  <= NW'(1);
         edge_count_ff <= '0;
         anchor_ff     <= '0;
         overflow_ff   <= 1'b0;
         cost_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         num_nodes_ff  <= num_nodes_in;
         edge_count_ff <= edge_count_in;
         anchor_ff     <= anchor_in;
         overflow_ff   <= overflow_in;
         cost_ff       <= cost_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      pend_ff     <= pend_in;
      best_idx_ff <= best_idx_in;
      first_ff    <= first_in;
      best_ff     <= best_in;
      cur_ff      <= cur_in;
      ub_ff       <= ub_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      stage_ff    <= stage_in;
      ctx_ff      <= ctx_in;
      k_ff        <= k_in;
      status_ff   <= status_in;
      total_ff    <= total_in;
   end

endmodule
`default_nettype wire

// ===== tb/sv/multi_source_kruskal_mst_checker.sv =====
// ----------------------------------------------------------------------------
// multi_source_kruskal_mst_checker
// Watches the request, response and CSR channels, keeps its own copy of the
// node count and of the job's sets and edges, works out the status and cost
// due for each finish transaction and compares every response with it.
// ----------------------------------------------------------------------------
module multi_source_kruskal_mst_checker (
   input  logic clock,
   input  logic reset,
   msk_req_if   req,
   msk_rsp_if   rsp,
   msk_csr_if   csr,
   output int   failures,
   output int   pending,
   output int   results_seen
);

   typedef struct packed {
      logic [msk_pkg::STATUS_W-1:0] status;
      logic [msk_pkg::COST_W-1:0]   cost;
   } outcome_type;

   outcome_type                outcomes_due[$];
   logic [msk_pkg::NODE_W-1:0] node_limit;
   int unsigned                link_to[msk_pkg::MAX_NODES_DEF];
   msk_pkg::edge_type          job_edges[$];
   int unsigned                anchor;
   bit                         spilled;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      failures++;
   endtask

   function automatic void clear_job();
      for (int i = 0; i < msk_pkg::MAX_NODES_DEF; i++) link_to[i] = i;
      job_edges.delete();
      anchor  = 0;
      spilled = 0;
   endfunction

   function automatic int unsigned root_find(input int unsigned slot);
      int unsigned r, nxt;
      r = slot;
      while (link_to[r] != r) r = link_to[r];
      while (link_to[slot] != r) begin
         nxt = link_to[slot];
         link_to[slot] = r;
         slot = nxt;
      end
      return r;
   endfunction

   function automatic bit join_roots(input int unsigned s, input int unsigned t);
      int unsigned ra, rb;
      ra = root_find(s);
      rb = root_find(t);
      if (ra == rb) return 0;
      link_to[rb] = ra;
      return 1;
   endfunction

   function automatic outcome_type solve_job();
      msk_pkg::edge_type          by_weight[$];
      msk_pkg::edge_type          e;
      int unsigned                nn, r0, na, nb;
      int                         j;
      logic [msk_pkg::COST_W-1:0] sum;
      outcome_type                o;
      if (spilled) begin
         o.status = msk_pkg::ST_OVERFLOW;
         o.cost   = '0;
         return o;
      end
      nn = (32'(node_limit) > msk_pkg::MAX_NODES_DEF) ? msk_pkg::MAX_NODES_DEF
                                                      : 32'(node_limit);
      foreach (job_edges[i]) begin
         e = job_edges[i];
         j = by_weight.size();
         while (j > 0 && by_weight[j-1].weight > e.weight) j--;
         by_weight.insert(j, e);
      end
      sum = '0;
      foreach (by_weight[i]) begin
         e  = by_weight[i];
         na = 32'(e.node_a);
         nb = 32'(e.node_b);
         if (na < 1 || na > nn || nb < 1 || nb > nn) continue;
         if (join_roots(na - 1, nb - 1)) sum = sum + msk_pkg::COST_W'(e.weight);
      end
      o.status = msk_pkg::ST_CONNECTED;
      o.cost   = sum;
      if (nn >= 2) begin
         r0 = root_find(0);
         for (int unsigned i = 1; i < nn; i++) begin
            if (root_find(i) != r0) begin
               o.status = msk_pkg::ST_SPLIT;
               o.cost   = '0;
               break;
            end
         end
      end
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type o;
      int unsigned na;
      if (reset) begin
         node_limit = msk_pkg::NODE_W'(1);
         clear_job();
         outcomes_due.delete();
         failures     = 0;
         results_seen = 0;
      end else begin
         if (csr.valid && csr.ready) node_limit = csr.num_nodes;
         if (req.valid && req.ready) begin
            na = 32'(req.node_a);
            case (req.req_type)
               msk_pkg::REQ_SOURCE: begin
                  if (na >= 1 && na <= msk_pkg::MAX_NODES_DEF) begin
                     if (anchor == 0) anchor = na;
                     else void'(join_roots(anchor - 1, na - 1));
                  end
               end
               msk_pkg::REQ_EDGE: begin
                  if (job_edges.size() >= msk_pkg::MAX_EDGES_DEF) spilled = 1;
                  else job_edges.push_back({req.node_a, req.node_b, req.weight});
               end
               msk_pkg::REQ_FINISH: begin
                  outcomes_due.push_back(solve_job());
                  clear_job();
               end
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            if (outcomes_due.size() == 0) begin
               report_mismatch("response with nothing outstanding");
            end else begin
               o = outcomes_due.pop_front();
               if (rsp.status !== o.status)
                  report_mismatch($sformatf("status %0d, wanted %0d", rsp.status, o.status));
               if (rsp.total_cost !== o.cost)
                  report_mismatch($sformatf("total_cost %0d, wanted %0d",
                                            rsp.total_cost, o.cost));
            end
         end
      end
      pending = outcomes_due.size();
   end
endmodule

// ===== tb/sv/multi_source_kruskal_mst_test.sv =====
// ----------------------------------------------------------------------------
// multi_source_kruskal_mst_test
// Drives source, edge and finish transactions and node count writes into the
// spanning tree engine under rotating idle and stall patterns; the checker
// beside the block predicts every response and counts mismatches.
// ----------------------------------------------------------------------------
module multi_source_kruskal_mst_test;

   localparam logic [msk_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   int          failures, pending, results_seen;
   int          idle_phase;
   int          items_sent, finishes_sent, jobs_run;
   int unsigned node_cfg;

   msk_req_if req_ch ();
   msk_rsp_if rsp_ch ();
   msk_csr_if csr_ch ();

   multi_source_kruskal_mst dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch)
   );

   multi_source_kruskal_mst_checker checker_i (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch),
      .failures(failures), .pending(pending), .results_seen(results_seen)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_pct();
      return (idle_phase == 1) ? 46 : (idle_phase == 3) ? 21 : 0;
   endfunction

   always @(posedge clock) begin
      case (idle_phase)
         2:       rsp_ch.ready <= ($urandom_range(99) >= 46);
         3:       rsp_ch.ready <= ($urandom_range(99) >= 21);
         default: rsp_ch.ready <= 1'b1;
      endcase
   end

   task automatic send_req(input logic [msk_pkg::TYPE_W-1:0] kind, input int unsigned a,
                           input int unsigned b, input int unsigned w);
      if ($urandom_range(99) < gap_pct()) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.node_a   <= a[msk_pkg::NODE_W-1:0];
      req_ch.node_b   <= b[msk_pkg::NODE_W-1:0];
      req_ch.weight   <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      if (kind == msk_pkg::REQ_FINISH) finishes_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_seen < finishes_sent) @(posedge clock);
   endtask

   task automatic write_nodes(input int unsigned v);
      drain();
      csr_ch.valid     <= 1'b1;
      csr_ch.num_nodes <= v[msk_pkg::NODE_W-1:0];
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      node_cfg = v;
   endtask

   task automatic run_job();
      int unsigned len, pick, top_node;
      bit          ties;
      len      = $urandom_range(2, 36);
      ties     = 1'($urandom_range(1));
      top_node = (node_cfg + 1 > msk_pkg::MAX_NODES_DEF) ? msk_pkg::MAX_NODES_DEF
                                                          : node_cfg + 1;
      for (int unsigned k = 0; k < len; k++) begin
         pick = $urandom_range(99);
         if (pick < 3)
            send_req(REQ_UNUSED, $urandom_range(2047), $urandom_range(2047), $urandom);
         else if (pick < 8)
            send_req(pick < 5 ? msk_pkg::REQ_SOURCE : msk_pkg::REQ_EDGE,
                     $urandom_range(2047), $urandom_range(2047), $urandom);
         else if (pick < 25)
            send_req(msk_pkg::REQ_SOURCE, $urandom_range(1, top_node),
                     $urandom_range(2047), $urandom);
         else
            send_req(msk_pkg::REQ_EDGE, $urandom_range(1, top_node),
                     $urandom_range(1, top_node), ties ? $urandom_range(0, 7) : $urandom);
      end
      send_req(msk_pkg::REQ_FINISH, $urandom_range(2047), $urandom_range(2047), $urandom);
      jobs_run++;
   endtask

   initial begin
      int unsigned pick;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = msk_pkg::REQ_SOURCE;
      req_ch.node_a    = '0;
      req_ch.node_b    = '0;
      req_ch.weight    = '0;
      csr_ch.valid     = 1'b0;
      csr_ch.num_nodes = '0;
      rsp_ch.ready     = 1'b1;
      idle_phase = 0;
      items_sent = 0;
      finishes_sent = 0;
      jobs_run = 0;
      node_cfg = 1;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: single node, no nodes, then a small graph with the odd cases
      send_req(msk_pkg::REQ_FINISH, 0, 0, 0);
      write_nodes(0);
      send_req(msk_pkg::REQ_EDGE, 1, 2, 9);
      send_req(msk_pkg::REQ_FINISH, 0, 0, 0);
      write_nodes(4);
      send_req(msk_pkg::REQ_SOURCE, 1, 0, 0);
      send_req(msk_pkg::REQ_SOURCE, 0, 0, 0);
      send_req(msk_pkg::REQ_SOURCE, 1025, 0, 0);
      send_req(msk_pkg::REQ_SOURCE, 2047, 0, 0);
      send_req(msk_pkg::REQ_SOURCE, 1024, 0, 0);
      send_req(msk_pkg::REQ_SOURCE, 3, 0, 0);
      send_req(REQ_UNUSED, 2, 4, 1);
      send_req(msk_pkg::REQ_EDGE, 1, 2, 32'hFFFF_FFFF);
      send_req(msk_pkg::REQ_EDGE, 2, 3, 0);
      send_req(msk_pkg::REQ_EDGE, 4, 3, 5);
      send_req(msk_pkg::REQ_EDGE, 4, 2, 5);
      send_req(msk_pkg::REQ_EDGE, 4, 5, 1);
      send_req(msk_pkg::REQ_EDGE, 0, 4, 1);
      send_req(msk_pkg::REQ_FINISH, 0, 0, 0);
      send_req(msk_pkg::REQ_EDGE, 1, 2, 3);
      send_req(msk_pkg::REQ_FINISH, 0, 0, 0);

      // random jobs, idle pattern rotating per job
      while (items_sent < 1370) begin
         idle_phase = jobs_run % 4;
         if ($urandom_range(2) == 0) begin
            pick = $urandom_range(19);
            write_nodes(pick == 0 ? 2047 : pick == 1 ? 1024 : pick == 2 ?
                        $urandom_range(2047) : $urandom_range(0, 10));
         end
         run_job();
         drain();
      end

      // full node range with a few sources, then an oversized count
      idle_phase = 3;
      write_nodes(1024);
      send_req(msk_pkg::REQ_SOURCE, 1, 0, 0);
      send_req(msk_pkg::REQ_SOURCE, 1024, 0, 0);
      send_req(msk_pkg::REQ_SOURCE, 512, 0, 0);
      send_req(msk_pkg::REQ_EDGE, 1024, 1, 11);
      send_req(msk_pkg::REQ_FINISH, 0, 0, 0);
      write_nodes(2047);
      send_req(msk_pkg::REQ_EDGE, 1, 2, 4);
      send_req(msk_pkg::REQ_FINISH, 0, 0, 0);

      drain();
      repeat (1200) @(posedge clock);
      $display("covered %0d transactions in %0d jobs, %0d responses checked",
               items_sent, finishes_sent, results_seen);
      $display("node counts from zero to the 11-bit maximum, ignored requests and ties");
      if (failures == 0 && pending == 0) begin
         $display("[multi_source_kruskal_mst] OK");
      end else begin
         $display("%0d mismatches, %0d responses outstanding", failures, pending);
         $display("[multi_source_kruskal_mst] ERROR");
      end
      $finish;
   end

   initial begin
      #400_000_000;
      $display("run timed out");
      $display("[multi_source_kruskal_mst] ERROR");
      $finish;
   end
endmodule
